>>> hdl/mskf_pkg.sv
// ----------------------------------------------------------------------------
// mskf_pkg
// Shared types and constants of the multichannel scalar Kalman filter.
// ----------------------------------------------------------------------------
package mskf_pkg;

  localparam int unsigned CH_W    = 3;   // channel tag width
  localparam int unsigned SMP_W   = 12;  // converter sample width
  localparam int unsigned FRAC_W  = 16;  // fractional bits of all Q formats
  localparam int unsigned EST_W   = SMP_W + FRAC_W;  // Q12.16 estimate
  localparam int unsigned COV_W   = 32;  // Q16.16 covariance / noise
  localparam int unsigned GAIN_W  = FRAC_W;          // Q0.16 gain
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned DIV_STEPS = FRAC_W + 1;    // quotient bits produced
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [COV_W-1:0]  ONE_Q16        = 32'd65536;
  localparam logic [COV_W-1:0]  Q_NOISE_RESET  = 32'd655;
  localparam logic [COV_W-1:0]  R_NOISE_RESET  = 32'd655360;
  localparam logic [GAIN_W-1:0] GAIN_MAX       = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MEASUREMENT_NOISE = 2'd1;

  // per-channel filter state as kept in the state memory
  typedef struct packed {
    logic [SMP_W-1:0] last_output;
    logic [COV_W-1:0] covariance;
    logic [EST_W-1:0] estimate;
  } mskf_entry_t;

  localparam mskf_entry_t ENTRY_RESET = '{
    last_output: '0,
    covariance:  ONE_Q16,
    estimate:    '0
  };

endpackage

>>> hdl/mskf_if.sv
// ----------------------------------------------------------------------------
// mskf channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mskf_in_if import mskf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mskf_out_if import mskf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  result_channel;
  logic [SMP_W-1:0] filtered_value;
  logic             was_seeded;

  modport source (output valid, output result_channel, output filtered_value,
                  output was_seeded, input ready);
  modport sink   (input valid, input result_channel, input filtered_value,
                  input was_seeded, output ready);
endinterface

interface mskf_cfg_if import mskf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [COV_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/mskf_div.sv
// ----------------------------------------------------------------------------
// mskf_div
// Radix-2 restoring divider for the Kalman gain K = P'*2^16 / (P'+R).
// ----------------------------------------------------------------------------
module mskf_div import mskf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [COV_W-1:0]  num_i,
  input  logic [COV_W:0]    den_i,
  output logic              done_o,
  output logic [GAIN_W-1:0] quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [COV_W:0]       rem_q, rem_d;
  logic [COV_W:0]       den_q;
  logic [FRAC_W:0]      bits_q;
  logic [FRAC_W:0]      quot_q;
  logic [COV_W+1:0]     trial;
  logic [COV_W+1:0]     diff;
  logic                 qbit;

  // num <= den, so the quotient fits 17 bits; the top numerator bits are
  // preloaded and only the last 17 are shifted through
  assign trial = {rem_q, bits_q[FRAC_W]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = trial >= {1'b0, den_q};
  assign rem_d = qbit ? diff[COV_W:0] : trial[COV_W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= (den_i != '0);
        done_q <= (den_i == '0);
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, num_i[COV_W-1:1]};
      bits_q <= {num_i[0], {FRAC_W{1'b0}}};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      bits_q <= {bits_q[FRAC_W-1:0], 1'b0};
      quot_q <= {quot_q[FRAC_W-1:0], qbit};
    end
  end

  assign done_o = done_q;
  // K reaches 1.0 only with R = 0; clamp to just below one
  assign quot_o = quot_q[FRAC_W] ? GAIN_MAX : quot_q[GAIN_W-1:0];

endmodule

>>> hdl/multichannel_scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// multichannel_scalar_kalman_filter_unit
// Per-channel scalar Kalman filter over tagged converter samples.
// ----------------------------------------------------------------------------
//  port    | dir | transaction contents
//  --------+-----+-----------------------------------------------
//  smp_i   | in  | channel, sample
//  res_o   | out | result_channel, filtered_value, was_seeded
//  cfg_i   | in  | index (0: Q, 1: R), data
//
//  An item runs through one state memory read, predict, a 17-step
//  restoring divide for the gain, two multiplies and the write-back. A
//  seeded item skips the divide and multiplies; a zero P'+R ends the
//  divide at once; an out-of-range channel is dropped in its accept
//  cycle. One item is in flight at a time.
//  Reset puts every channel at estimate 0, covariance 1.0 through per-entry
//  valid bits; no clearing pass. A held result stalls only the write-back.
// ----------------------------------------------------------------------------
module multichannel_scalar_kalman_filter_unit import mskf_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mskf_in_if.sink    smp_i,
  mskf_out_if.source res_o,
  mskf_cfg_if.sink   cfg_i
);

  localparam int unsigned CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_DIVST, ST_DIV, ST_GAIN, ST_COV, ST_WB
  } state_e;

  state_e state_q;

  logic [COV_W-1:0] q_noise_q, r_noise_q;

  // state memory
  mskf_entry_t              mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  vld_q;
  mskf_entry_t              rd_data_q;
  logic                     rd_vld_q;
  mskf_entry_t              entry;

  logic             in_acc;
  logic             in_range;
  logic [CH_AW-1:0] in_idx;
  logic             wb_go;

  // item payload
  logic [CH_AW-1:0]  idx_q;
  logic [CH_W-1:0]   ch_q;
  logic [EST_W-1:0]  est_q, target_q, est_new_q, diff_q;
  logic              up_q;
  logic              seeded_q;
  logic [COV_W-1:0]  cov_q, p_pred_q;
  logic [GAIN_W+EST_W-1:0]  prod1_q;
  logic [FRAC_W+COV_W:0]    prod2_q;
  logic [COV_W:0]    psum;
  logic [COV_W:0]    den;
  logic [EST_W-1:0]  corr;
  logic [COV_W-1:0]  cov_new;

  logic              div_start;
  logic              div_done;
  logic [GAIN_W-1:0] gain;

  // output register
  logic              out_vld_q;
  logic [CH_W-1:0]   out_ch_q;
  logic [SMP_W-1:0]  out_val_q;
  logic              out_seed_q;

  assign in_range = (32'(smp_i.channel) < NUM_CHANNELS);
  assign in_idx   = CH_AW'(smp_i.channel);
  assign in_acc   = smp_i.valid && smp_i.ready;
  assign smp_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign wb_go    = (state_q == ST_WB) && (!out_vld_q || res_o.ready);

  assign entry  = rd_vld_q ? rd_data_q : ENTRY_RESET;
  assign psum   = {1'b0, entry.covariance} + {1'b0, q_noise_q};
  assign den    = {1'b0, p_pred_q} + {1'b0, r_noise_q};
  assign corr   = prod1_q[GAIN_W+EST_W-1:FRAC_W];
  assign cov_new = seeded_q ? cov_q : prod2_q[FRAC_W+COV_W-1:FRAC_W];
  assign div_start = (state_q == ST_DIVST);

  mskf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p_pred_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (gain)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= Q_NOISE_RESET;
      r_noise_q <= R_NOISE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_PROCESS_NOISE:     q_noise_q <= cfg_i.data;
        REG_MEASUREMENT_NOISE: r_noise_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // memory: read on accept, write on write-back
  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      rd_data_q <= mem_q[in_idx];
    end
    if (wb_go) begin
      mem_q[idx_q] <= '{last_output: est_new_q[EST_W-1:FRAC_W],
                        covariance:  cov_new,
                        estimate:    est_new_q};
    end
  end

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && res_o.ready && !wb_go) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_range) begin
            rd_vld_q <= vld_q[in_idx];
            state_q  <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_q <= (entry.last_output == '0 && entry.estimate == '0) ? ST_WB : ST_DIVST;
        end
        ST_DIVST: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: state_q <= ST_COV;
        ST_COV:  state_q <= ST_WB;
        ST_WB: begin
          if (wb_go) begin
            vld_q[idx_q] <= 1'b1;
            out_vld_q    <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_q    <= in_idx;
          ch_q     <= smp_i.channel;
          target_q <= {smp_i.sample, {FRAC_W{1'b0}}};
        end
      end
      ST_SETUP: begin
        est_q    <= entry.estimate;
        cov_q    <= entry.covariance;
        p_pred_q <= psum[COV_W] ? {COV_W{1'b1}} : psum[COV_W-1:0];
        seeded_q <= (entry.last_output == '0 && entry.estimate == '0);
        est_new_q <= target_q;
        up_q     <= (target_q >= entry.estimate);
        diff_q   <= (target_q >= entry.estimate) ? target_q - entry.estimate
                                                 : entry.estimate - target_q;
      end
      ST_GAIN: begin
        prod1_q <= gain * diff_q;
      end
      ST_COV: begin
        prod2_q   <= (ONE_Q16[FRAC_W:0] - {1'b0, gain}) * p_pred_q;
        est_new_q <= up_q ? est_q + corr : est_q - corr;
      end
      ST_WB: begin
        if (wb_go) begin
          out_ch_q   <= ch_q;
          out_val_q  <= est_new_q[EST_W-1:FRAC_W];
          out_seed_q <= seeded_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.result_channel = out_ch_q;
  assign res_o.filtered_value = out_val_q;
  assign res_o.was_seeded     = out_seed_q;

endmodule

>>> bench/kalman_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_result_checker
// Watches the sample, result and configuration channels of the filter unit,
// keeps its own per-channel filter state, predicts each result and compares.
// ----------------------------------------------------------------------------
module kalman_result_checker import mskf_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  mskf_in_if   smp,
  mskf_out_if  res,
  mskf_cfg_if  cfg,
  output int   mismatch_count_o,
  output int   outstanding_o
);

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] value;
    logic             seeded;
  } filt_result_t;

  logic [COV_W-1:0] q_noise;
  logic [COV_W-1:0] r_noise;
  logic [EST_W-1:0] est_mem  [NUM_CHANNELS];
  logic [COV_W-1:0] cov_mem  [NUM_CHANNELS];
  logic [SMP_W-1:0] last_mem [NUM_CHANNELS];

  filt_result_t predicted_results[$];

  // one filter step on the local state copy
  function automatic filt_result_t filter_update(input logic [CH_W-1:0] ch,
                                                 input logic [SMP_W-1:0] smp_val);
    logic [EST_W-1:0]  target;
    logic [EST_W-1:0]  est;
    logic [EST_W-1:0]  corr;
    logic [COV_W:0]    psum;
    logic [COV_W:0]    den;
    logic [COV_W-1:0]  p_pred;
    logic [63:0]       quot;
    logic [63:0]       prod;
    logic [GAIN_W-1:0] gain;
    logic [GAIN_W:0]   one_minus_gain;
    filt_result_t      upd;
    target = {smp_val, {FRAC_W{1'b0}}};
    est    = est_mem[ch];
    if (last_mem[ch] == '0 && est == '0) begin
      est        = target;
      upd.seeded = 1'b1;
    end else begin
      psum   = {1'b0, cov_mem[ch]} + {1'b0, q_noise};
      p_pred = psum[COV_W] ? '1 : psum[COV_W-1:0];
      den    = {1'b0, p_pred} + {1'b0, r_noise};
      if (den == '0) begin
        gain = '0;
      end else begin
        quot = {16'b0, p_pred, 16'b0} / {31'b0, den};
        gain = (quot > 64'(GAIN_MAX)) ? GAIN_MAX : quot[GAIN_W-1:0];
      end
      if (target >= est) begin
        prod = 64'(gain) * 64'(target - est);
        corr = EST_W'(prod >> FRAC_W);
        est  = est + corr;
      end else begin
        prod = 64'(gain) * 64'(est - target);
        corr = EST_W'(prod >> FRAC_W);
        est  = est - corr;
      end
      one_minus_gain = 17'(ONE_Q16) - 17'(gain);
      prod           = 64'(one_minus_gain) * 64'(p_pred);
      cov_mem[ch]    = COV_W'(prod >> FRAC_W);
      upd.seeded     = 1'b0;
    end
    est_mem[ch]   = est;
    last_mem[ch]  = est[EST_W-1:FRAC_W];
    upd.channel   = ch;
    upd.value     = est[EST_W-1:FRAC_W];
    return upd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_result_t want;
    if (!rst_ni) begin
      q_noise = Q_NOISE_RESET;
      r_noise = R_NOISE_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        est_mem[i]  = '0;
        cov_mem[i]  = ONE_Q16;
        last_mem[i] = '0;
      end
      predicted_results.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
    end else begin
      // result side first: with one item in flight it belongs to an older transaction
      if (res.valid && res.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transaction with nothing expected: ch %0d value %0d",
                 res.result_channel, res.filtered_value);
          mismatch_count_o++;
        end else begin
          want = predicted_results.pop_front();
          if (res.result_channel !== want.channel) begin
            $error("result_channel: expected %0d, got %0d",
                   want.channel, res.result_channel);
            mismatch_count_o++;
          end
          if (res.filtered_value !== want.value) begin
            $error("filtered_value: expected %0d, got %0d",
                   want.value, res.filtered_value);
            mismatch_count_o++;
          end
          if (res.was_seeded !== want.seeded) begin
            $error("was_seeded: expected %0d, got %0d",
                   want.seeded, res.was_seeded);
            mismatch_count_o++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PROCESS_NOISE:     q_noise = cfg.data;
          REG_MEASUREMENT_NOISE: r_noise = cfg.data;
          default: ;
        endcase
      end
      // out-of-range channels are dropped by the block
      if (smp.valid && smp.ready && smp.channel < NUM_CHANNELS)
        predicted_results.push_back(filter_update(smp.channel, smp.sample));
      outstanding_o = predicted_results.size();
    end
  end

endmodule

>>> bench/tb_multichannel_scalar_kalman_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_scalar_kalman_filter_unit
// Drives directed and random tagged samples and noise settings into the
// filter unit under several idle/stall patterns; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_multichannel_scalar_kalman_filter_unit;
  import mskf_pkg::*;

  localparam int unsigned NUM_CHANNELS = 6;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          SETTLE       = 40;    // above the item latency
  localparam logic [CFG_AW-1:0] REG_UNMAPPED = 2'd3;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycle_count;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_req;
  int   hold_left;

  mskf_in_if  smp_if ();
  mskf_out_if res_if ();
  mskf_cfg_if cfg_if ();

  multichannel_scalar_kalman_filter_unit #(.NUM_CHANNELS(NUM_CHANNELS)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .smp_i  (smp_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  kalman_result_checker #(.NUM_CHANNELS(NUM_CHANNELS)) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .smp              (smp_if),
    .res              (res_if),
    .cfg              (cfg_if),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus an occasional long hold-off
  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk);
    end
    smp_if.valid   <= 1'b1;
    smp_if.channel <= ch;
    smp_if.sample  <= s;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [COV_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // block idle: no result outstanding and any dropped item long gone
  task automatic wait_drained();
    @(negedge clk);
    smp_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [COV_W-1:0] pick_noise(input logic [COV_W-1:0] dflt);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return dflt;
      3, 4:    return $urandom_range(0, 32'h0004_0000);
      5:       return $urandom;
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  task automatic run_random(input int n, input int hold_len, input int pause_at);
    int               accepted;
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] s;
    accepted = 0;
    hold_req = hold_len;
    while (accepted < n) begin
      ch = ($urandom_range(99) < 8) ? CH_W'($urandom_range(7)) :
                                      CH_W'($urandom_range(NUM_CHANNELS - 1));
      case ($urandom_range(9))
        0:       s = '0;
        1:       s = '1;
        default: s = SMP_W'($urandom);
      endcase
      push_sample(ch, s);
      if (ch < NUM_CHANNELS) begin
        accepted++;
        if (accepted == pause_at) wait_drained();
      end
    end
  endtask

  initial begin
    int idle_modes [4][2];
    idle_modes = '{'{0, 0}, '{81, 0}, '{0, 81}, '{36, 36}};
    rst_n          = 1'b0;
    smp_if.valid   = 1'b0;
    smp_if.channel = '0;
    smp_if.sample  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset noise settings
    push_sample(0, 0);        // seed with zero keeps the channel unseeded
    push_sample(0, 4095);     // seeds again
    push_sample(0, 0);
    push_sample(1, 4095);
    push_sample(1, 4095);
    push_sample(1, 0);
    push_sample(5, 2048);
    push_sample(6, 1234);     // out of range, dropped
    push_sample(7, 4095);     // out of range, dropped
    push_sample(2, 1);
    push_sample(2, 0);
    wait_drained();

    // zero noise: gain saturates, covariance collapses to the zero denominator
    write_reg(REG_PROCESS_NOISE, '0);
    write_reg(REG_MEASUREMENT_NOISE, '0);
    write_reg(REG_UNMAPPED, 32'h1234_5678);
    push_sample(3, 100);
    push_sample(3, 4000);
    push_sample(3, 0);
    push_sample(3, 2222);
    push_sample(4, 12'h800);
    push_sample(4, 12'h7FF);
    push_sample(4, 0);
    push_sample(4, 4095);
    wait_drained();

    // saturated prediction sum
    write_reg(REG_PROCESS_NOISE, '1);
    write_reg(REG_MEASUREMENT_NOISE, '1);
    push_sample(0, 1234);
    push_sample(5, 0);
    push_sample(1, 4095);
    push_sample(2, 3000);
    wait_drained();

    for (int m = 0; m < 4; m++) begin
      for (int c = 0; c < 3; c++) begin
        wait_drained();
        send_idle_pct = idle_modes[m][0];
        stall_pct     = idle_modes[m][1];
        write_reg(REG_PROCESS_NOISE, pick_noise(Q_NOISE_RESET));
        write_reg(REG_MEASUREMENT_NOISE, pick_noise(R_NOISE_RESET));
        if (c == 2) write_reg(REG_UNMAPPED, $urandom);
        run_random(100, (m == 0 && c == 0) ? 400 : 0, (c == 1) ? 50 : 0);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
